// File: src/mexp_pkg.sv
// Package with shared constants, types and the control enum for modular exponentiation.
`timescale 1ns / 1ps
package mexp_pkg;
   localparam int MOD_W = 32;
   localparam int BASE_W = 64;
   localparam int EXP_W = 64;
   localparam int BCNT_W = $clog2(BASE_W + 1);
   localparam int MCNT_W = $clog2(MOD_W + 1);
   localparam int ECNT_W = $clog2(EXP_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REDUCE, ST_FIX, ST_MUL_R, ST_MUL_B, ST_NEXT, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } mul_ctl_type;
endpackage

// File: src/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-add with conditional subtract.
`timescale 1ns / 1ps
module mexp_mulmod import mexp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MOD_W-1:0] a_in,
   input  logic [MOD_W-1:0] b_in,
   input  logic [MOD_W-1:0] m_in,
   output mul_ctl_type      ctl,
   output logic [MOD_W-1:0] product
);
   logic [MOD_W-1:0] a_ff, a_in_nx, b_ff, b_in_nx, acc_ff, acc_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [MOD_W:0]   acc_sum, a_dbl;

   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, a_ff};
      a_dbl   = {a_ff, 1'b0};
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in_nx = a_in;
         b_in_nx = b_in;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = (acc_sum >= {1'b0, m_in}) ? MOD_W'(acc_sum - {1'b0, m_in})
                                                   : acc_sum[MOD_W-1:0];
            end
            a_in_nx = (a_dbl >= {1'b0, m_in}) ? MOD_W'(a_dbl - {1'b0, m_in})
                                               : a_dbl[MOD_W-1:0];
            b_in_nx = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in_nx;
      b_ff   <= b_in_nx;
      acc_ff <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign product   = acc_ff;
endmodule

// File: src/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply modular exponentiation engine.
// The base is reduced first, then each exponent bit takes up to two bit-serial
// multiplications: a multiply into the result when the bit is set, and a squaring.
// A zero modulus or a non-positive exponent goes straight to the done state.
// One item at a time: the next request is taken once the residue is transferred.
// Reset (synchronous, active high) returns the controller to idle with no result pending.
`timescale 1ns / 1ps
module modular_exponentiation import mexp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [BASE_W-1:0] req_base_value,
   input  logic signed [EXP_W-1:0]  req_exponent,
   input  logic [MOD_W-1:0]         req_modulus,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MOD_W-1:0]         rsp_residue
);
   state_type state_ff, state_in;

   // Operand registers. The base magnitude is reduced by restoring division, one
   // dividend bit per cycle, shifting out of mag_ff into the partial remainder.
   logic [BASE_W-1:0] mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic [MOD_W-1:0]  m_ff, m_in;
   logic [MOD_W-1:0]  b_ff, b_in;
   logic [MOD_W-1:0]  res_ff, res_in;
   logic [BCNT_W-1:0] cnt_ff, cnt_in;
   logic              vld_ff, vld_in;
   logic [MOD_W:0]    rem_sh;

   // A single shared multiplier serves both the result and the square updates.
   logic              mul_start;
   logic [MOD_W-1:0]  mul_a, mul_b, mul_p;
   mul_ctl_type       mul_ctl;

   mexp_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a_in(mul_a), .b_in(mul_b), .m_in(m_ff), .ctl(mul_ctl), .product(mul_p)
   );

   assign req_ready   = (state_ff == ST_IDLE) && !vld_ff;
   assign rsp_valid   = vld_ff;
   assign rsp_residue = res_ff;
   assign rem_sh      = {b_ff, mag_ff[BASE_W-1]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid && req_ready) begin
            if (req_modulus == '0 || req_exponent[EXP_W-1] || req_exponent == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: if (cnt_ff == BCNT_W'(BASE_W - 1)) state_in = ST_FIX;
         ST_FIX:    state_in = exp_ff[0] ? ST_MUL_R : ST_MUL_B;
         ST_MUL_R:  if (mul_ctl.done) state_in = ST_MUL_B;
         ST_MUL_B:  if (mul_ctl.done) state_in = ST_NEXT;
         ST_NEXT:   begin
            if (exp_ff == '0) state_in = ST_DONE;
            else if (exp_ff[0]) state_in = ST_MUL_R;
            else state_in = ST_MUL_B;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      exp_in    = exp_ff;
      m_in      = m_ff;
      b_in      = b_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      vld_in    = vld_ff;
      mul_start = 1'b0;
      mul_a     = res_ff;
      mul_b     = b_ff;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            neg_in = req_base_value[BASE_W-1];
            mag_in = req_base_value[BASE_W-1] ? BASE_W'(-req_base_value)
                                              : req_base_value;
            exp_in = req_exponent;
            m_in   = req_modulus;
            b_in   = '0;
            cnt_in = '0;
            // Zero modulus gives 0; otherwise a non-positive exponent gives 1.
            res_in = (req_modulus == '0) ? '0 : MOD_W'(1);
         end
         ST_REDUCE: begin
            b_in   = (rem_sh >= {1'b0, m_ff}) ? MOD_W'(rem_sh - {1'b0, m_ff})
                                              : rem_sh[MOD_W-1:0];
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FIX: begin
            if (neg_ff && b_ff != '0) b_in = m_ff - b_ff;
            // The running result starts at 1 mod m.
            res_in = (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
            mul_start = 1'b1;
            mul_a = (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
            mul_b = (neg_ff && b_ff != '0) ? m_ff - b_ff : b_ff;
            if (!exp_ff[0]) mul_a = mul_b;
         end
         ST_MUL_R: if (mul_ctl.done) begin
            res_in    = mul_p;
            mul_start = 1'b1;
            mul_a     = b_ff;
            mul_b     = b_ff;
         end
         ST_MUL_B: if (mul_ctl.done) begin
            b_in   = mul_p;
            exp_in = exp_ff >> 1;
         end
         ST_NEXT: if (exp_ff != '0) begin
            mul_start = 1'b1;
            if (exp_ff[0]) begin
               mul_a = res_ff;
               mul_b = b_ff;
            end else begin
               mul_a = b_ff;
               mul_b = b_ff;
            end
         end
         ST_DONE: vld_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      exp_ff <= exp_in;
      m_ff   <= m_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   // A request is never taken while a result waits for its transfer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted with result pending");

   // The multiplier is only started while the controller is in a multiply phase.
   a_mul_phase: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (state_ff == ST_FIX || state_ff == ST_MUL_R || state_ff == ST_NEXT))
      else $error("multiplier started outside a multiply phase");

   // A result is valid in the cycle after the done state.
   a_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("done without result");
endmodule
